// File: rtl/tmq_pkg.sv
// Package for the typed message queue: sizes, status codes, controller states.
// No dependencies.
package tmq_pkg;
  localparam int MaxMessages = 16;
  localparam int IdxW = $clog2(MaxMessages);
  localparam int CntW = $clog2(MaxMessages + 1);
  localparam logic [15:0] LimitReset = 16'd4096;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_DROPPED = 3'd1, ST_INVALID = 3'd2, ST_BLOCK = 3'd3,
    ST_NOSPACE = 3'd4, ST_NOMSG = 3'd5, ST_TOOBIG = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SEND, S_WALK, S_CHECK, S_UNLINK, S_DONE
  } state_t;

  typedef enum logic [0:0] {OP_SEND = 1'b0, OP_RECV = 1'b1} op_t;

  typedef struct packed {
    logic [31:0] mtype;
    logic [15:0] size;
    logic [31:0] handle;
  } entry_t;

  typedef struct packed {
    logic            ewe;
    logic [IdxW-1:0] ewaddr;
    entry_t          ewdata;
    logic [IdxW-1:0] eraddr;
    logic            lwe;
    logic [IdxW-1:0] lwaddr;
    logic [IdxW-1:0] lwdata;
    logic [IdxW-1:0] lraddr;
  } mem_req_t;
endpackage

// File: rtl/tmq_store.sv
// Entry and link memories of the typed message queue, with registered reads.
// Depends on tmq_pkg. The link memory is initialized as a free list by a sweep.
module tmq_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tmq_pkg::mem_req_t         req,
  output tmq_pkg::entry_t           erdata,
  output logic [tmq_pkg::IdxW-1:0]  lrdata,
  output logic                      init_done
);
  import tmq_pkg::*;
  entry_t          emem [MaxMessages];
  logic [IdxW-1:0] lmem [MaxMessages];
  logic [IdxW-1:0] init_r;
  logic            init_done_r;

  always_ff @(posedge clk) begin
    if (req.ewe) emem[req.ewaddr] <= req.ewdata;
    erdata <= emem[req.eraddr];
  end

  always_ff @(posedge clk) begin
    if (!init_done_r) begin
      lmem[init_r] <= (32'(init_r) + 1 < MaxMessages) ? init_r + IdxW'(1) : '0;
    end else if (req.lwe) begin
      lmem[req.lwaddr] <= req.lwdata;
    end
    lrdata <= lmem[req.lraddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= '0;
      init_done_r <= 1'b0;
    end else if (!init_done_r) begin
      init_r <= init_r + IdxW'(1);
      if (32'(init_r) == MaxMessages - 1) init_done_r <= 1'b1;
    end
  end
  assign init_done = init_done_r;
endmodule

// File: rtl/typed_message_queue.sv
// Top level of the typed message queue: handshake, controller, config register.
// Depends on tmq_pkg and tmq_store.
// channel | direction | ports
// in      | input     | in_valid, in_stall, in_operation .. in_no_error
// out     | output    | out_valid, out_stall, out_status .. out_queued_count
// cfg     | APB write | psel, penable, pwrite, paddr, pwdata, prdata, pready
// A send passes through S_SEND. A receive alternates S_WALK and S_CHECK for each
// entry walked, with one link-memory read per step of the walk; a match goes on to
// S_UNLINK, and a delivered one to S_DONE. With no match the walk ends in S_WALK.
// After reset a sweep over all link entries chains the free list; no item is taken until then.
// A result waits in the output register; the next item is taken once it is gone.
module typed_message_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic signed [31:0] in_msg_type,
  input  logic signed [31:0] in_select_type,
  input  logic [15:0] in_length,
  input  logic [31:0] in_payload_handle,
  input  logic        in_no_error,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic signed [31:0] out_out_type,
  output logic [16:0] out_out_length,
  output logic [31:0] out_out_handle,
  output logic [15:0] out_queued_bytes,
  output logic [4:0]  out_queued_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tmq_pkg::*;

  state_t state_r, state_nxt;
  mem_req_t req;
  entry_t erdata;
  logic [IdxW-1:0] lrdata;
  logic init_done;

  logic [15:0] limit_r;
  logic [IdxW-1:0] head_r, tail_r, free_r, cur_r, prev_r;
  logic [CntW-1:0] count_r, k_r;
  logic [15:0] bytes_r;
  logic have_prev_r;
  logic noerr_r;
  logic signed [31:0] mtype_r, sel_r;
  logic [15:0] len_r;
  logic [31:0] hdl_r;
  logic out_valid_r;
  logic [2:0] st_r;
  logic [31:0] otype_r, ohdl_r;
  logic [16:0] olen_r;

  tmq_store u_store (.clk, .rst_n, .req, .erdata, .lrdata, .init_done);

  assign pready = 1'b1;
  assign prdata = paddr ? 32'd0 : {16'd0, limit_r};
  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= LimitReset;
    else if (psel && penable && pwrite && !paddr) limit_r <= pwdata[15:0];
  end

  wire accept = in_valid && !in_stall;
  assign in_stall = !(state_r == S_IDLE && init_done && !out_valid_r);

  logic sel_hit;
  logic signed [32:0] t33, s33;
  always_comb begin
    t33 = {erdata.mtype[31], erdata.mtype};
    s33 = {sel_r[31], sel_r};
    if (sel_r == 0) sel_hit = 1'b1;
    else if (!sel_r[31]) sel_hit = (t33 == s33);
    else sel_hit = (t33 <= -s33);
  end

  wire [16:0] sum17 = {1'b0, bytes_r} + {1'b0, len_r};
  wire send_ok = (len_r <= limit_r) && (sum17 <= {1'b0, limit_r})
                 && (32'(count_r) < MaxMessages);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = (in_operation == OP_RECV) ? S_WALK : S_SEND;
      S_SEND: state_nxt = S_IDLE;
      S_WALK: state_nxt = (k_r >= count_r) ? S_IDLE : S_CHECK;
      S_CHECK: state_nxt = sel_hit ? S_UNLINK : S_WALK;
      S_UNLINK: state_nxt = (st_r == ST_OK) ? S_DONE : S_IDLE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    req = '0;
    req.eraddr = cur_r;
    req.lraddr = cur_r;
    unique case (state_r)
      S_SEND: begin
        req.lraddr = free_r;
        req.ewe = send_ok;
        req.ewaddr = free_r;
        req.ewdata = '{mtype: mtype_r, size: len_r, handle: hdl_r};
        req.lwe = send_ok && (count_r != '0);
        req.lwaddr = tail_r;
        req.lwdata = free_r;
      end
      S_UNLINK: begin
        req.lwe = have_prev_r && (st_r == ST_OK);
        req.lwaddr = prev_r;
        req.lwdata = lrdata;
      end
      S_DONE: begin
        req.lwe = 1'b1;
        req.lwaddr = cur_r;
        req.lwdata = free_r;
      end
      default: ;
    endcase
    if (state_r == S_IDLE && accept) req.lraddr = free_r;
  end

  logic [IdxW-1:0] nxt_cur_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= '0; tail_r <= '0; free_r <= '0;
      count_r <= '0; bytes_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (accept) begin
          noerr_r <= in_no_error;
          mtype_r <= in_msg_type; sel_r <= in_select_type;
          len_r <= in_length; hdl_r <= in_payload_handle;
          cur_r <= head_r; k_r <= '0; have_prev_r <= 1'b0; prev_r <= '0;
        end
        S_SEND: begin
          otype_r <= '0; olen_r <= '0; ohdl_r <= '0;
          out_valid_r <= 1'b1;
          if (len_r > limit_r) st_r <= noerr_r ? ST_DROPPED : ST_INVALID;
          else if (sum17 > {1'b0, limit_r}) st_r <= ST_BLOCK;
          else if (32'(count_r) >= MaxMessages) st_r <= ST_NOSPACE;
          else begin
            st_r <= ST_OK;
            free_r <= lrdata;
            if (count_r == 0) head_r <= free_r;
            tail_r <= free_r;
            count_r <= count_r + CntW'(1);
            bytes_r <= sum17[15:0];
          end
        end
        S_WALK: if (k_r >= count_r) begin
          st_r <= ST_NOMSG; otype_r <= '0; olen_r <= '0; ohdl_r <= '0;
          out_valid_r <= 1'b1;
        end
        S_CHECK: begin
          nxt_cur_r <= lrdata;
          if (sel_hit) begin
            if (erdata.size > len_r && !noerr_r) begin
              st_r <= ST_TOOBIG;
              otype_r <= '0; olen_r <= '0; ohdl_r <= '0;
            end else begin
              st_r <= ST_OK;
              otype_r <= erdata.mtype; ohdl_r <= erdata.handle;
              olen_r <= 17'd4 + {1'b0, (erdata.size <= len_r) ? erdata.size : len_r};
              bytes_r <= (bytes_r >= erdata.size) ? bytes_r - erdata.size : '0;
            end
          end else begin
            prev_r <= cur_r; have_prev_r <= 1'b1;
            cur_r <= lrdata; k_r <= k_r + CntW'(1);
          end
        end
        S_UNLINK: begin
          if (st_r == ST_OK) begin
            count_r <= count_r - CntW'(1);
            if (count_r == CntW'(1)) begin
              head_r <= '0; tail_r <= '0;
            end else begin
              if (!have_prev_r) head_r <= nxt_cur_r;
              if (tail_r == cur_r) tail_r <= prev_r;
            end
          end else begin
            out_valid_r <= 1'b1;
          end
        end
        S_DONE: begin
          free_r <= cur_r;
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = st_r;
  assign out_out_type = otype_r;
  assign out_out_length = olen_r;
  assign out_out_handle = ohdl_r;
  assign out_queued_bytes = bytes_r;
  assign out_queued_count = count_r;
endmodule

// File: tb/tb_typed_message_queue.sv
// Testbench for typed_message_queue: directed and random send/receive traffic
// checked against an in-bench mailbox predictor. Depends on tmq_pkg and the RTL.
`timescale 1ns / 1ps

class mailbox_scoreboard;
  typedef struct {
    logic signed [31:0] mtype;
    logic [15:0]        size;
    logic [31:0]        handle;
  } msg_desc_t;

  typedef struct {
    logic [2:0]         status;
    logic signed [31:0] rtype;
    logic [16:0]        rlen;
    logic [31:0]        rhandle;
    logic [15:0]        qbytes;
    logic [4:0]         qcount;
  } reply_t;

  msg_desc_t held[$];
  reply_t    pending[$];
  int unsigned limit_bytes;
  int unsigned byte_sum;
  int errors;
  int checked;
  int recv_ok;

  function new();
    limit_bytes = 32'(tmq_pkg::LimitReset);
    byte_sum = 0;
    errors = 0;
    checked = 0;
    recv_ok = 0;
  endfunction

  function void set_limit(logic [15:0] v);
    limit_bytes = 32'(v);
  endfunction

  function void note_input(logic op, logic signed [31:0] mt, logic signed [31:0] sel,
                           logic [15:0] len, logic [31:0] hdl, logic noerr);
    reply_t r;
    msg_desc_t d;
    longint s;
    longint t;
    int hit;
    r.status = tmq_pkg::ST_OK;
    r.rtype = 0;
    r.rlen = 0;
    r.rhandle = 0;
    if (op == tmq_pkg::OP_SEND) begin
      if (len > limit_bytes) r.status = noerr ? tmq_pkg::ST_DROPPED : tmq_pkg::ST_INVALID;
      else if (byte_sum + len > limit_bytes) r.status = tmq_pkg::ST_BLOCK;
      else if (held.size() >= tmq_pkg::MaxMessages) r.status = tmq_pkg::ST_NOSPACE;
      else begin
        d.mtype = mt;
        d.size = len;
        d.handle = hdl;
        held.push_back(d);
        byte_sum += len;
      end
    end else begin
      s = sel;
      hit = -1;
      foreach (held[i]) begin
        t = held[i].mtype;
        if (hit < 0 && (s == 0 || (s > 0 && t == s) || (s < 0 && t <= -s))) hit = i;
      end
      if (hit < 0) r.status = tmq_pkg::ST_NOMSG;
      else if (held[hit].size > len && !noerr) r.status = tmq_pkg::ST_TOOBIG;
      else begin
        r.rtype = held[hit].mtype;
        r.rlen = 17'(4 + ((held[hit].size <= len) ? held[hit].size : len));
        r.rhandle = held[hit].handle;
        byte_sum -= held[hit].size;
        held.delete(hit);
        recv_ok++;
      end
    end
    r.qbytes = byte_sum[15:0];
    r.qcount = 5'(held.size());
    pending.push_back(r);
  endfunction

  function void check_result(logic [2:0] st, logic signed [31:0] ty, logic [16:0] ln,
                             logic [31:0] hd, logic [15:0] qb, logic [4:0] qc);
    reply_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected transaction status %0d", $time, st);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (st !== e.status || ty !== e.rtype || ln !== e.rlen || hd !== e.rhandle ||
        qb !== e.qbytes || qc !== e.qcount) begin
      $display("%0t: mismatch expected st=%0d ty=%0d len=%0d hd=%h qb=%0d qc=%0d", $time,
               e.status, e.rtype, e.rlen, e.rhandle, e.qbytes, e.qcount);
      $display("%0t:            actual st=%0d ty=%0d len=%0d hd=%h qb=%0d qc=%0d", $time,
               st, ty, ln, hd, qb, qc);
      errors++;
    end
  endfunction
endclass

module tb_typed_message_queue;
  import tmq_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic in_operation = 0;
  logic signed [31:0] in_msg_type = 0;
  logic signed [31:0] in_select_type = 0;
  logic [15:0] in_length = 0;
  logic [31:0] in_payload_handle = 0;
  logic in_no_error = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] out_status;
  logic signed [31:0] out_out_type;
  logic [16:0] out_out_length;
  logic [31:0] out_out_handle;
  logic [15:0] out_queued_bytes;
  logic [4:0] out_queued_count;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  mailbox_scoreboard mbox = new();
  bit quiet_tail = 0;
  int sent = 0;

  typed_message_queue dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      mbox.check_result(out_status, out_out_type, out_out_length, out_out_handle,
                        out_queued_bytes, out_queued_count);
  end

  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 11);
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
    end
  end

  task automatic write_limit(logic [15:0] v);
    @(posedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= 0;
    pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    mbox.set_limit(v);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (mbox.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic push_item(logic op, logic signed [31:0] mt, logic signed [31:0] sel,
                           logic [15:0] len, logic [31:0] hdl, logic noerr);
    int n;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 11);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    in_operation <= op;
    in_msg_type <= mt;
    in_select_type <= sel;
    in_length <= len;
    in_payload_handle <= hdl;
    in_no_error <= noerr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mbox.note_input(op, mt, sel, len, hdl, noerr);
    sent++;
  endtask

  task automatic random_item(int type_span);
    logic op;
    logic signed [31:0] mt;
    logic signed [31:0] sel;
    logic [15:0] len;
    int k;
    op = $urandom_range(0, 1);
    k = $urandom_range(0, 9);
    mt = (k == 0) ? $urandom : $signed($urandom_range(0, type_span)) - 2;
    k = $urandom_range(0, 9);
    if (k < 3) sel = 0;
    else if (k < 6) sel = $urandom_range(1, type_span);
    else if (k < 9) sel = -$signed($urandom_range(1, type_span));
    else sel = ($urandom_range(0, 1)) ? 32'sh8000_0001 : $urandom;
    k = $urandom_range(0, 9);
    len = (k == 0) ? 16'($urandom) : (k == 1) ? 16'hFFFF : 16'($urandom_range(0, 600));
    push_item(op, mt, sel, len, $urandom, $urandom_range(0, 1));
  endtask

  initial begin
    int i;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    // directed
    push_item(OP_RECV, 0, 0, 100, 0, 0);
    push_item(OP_SEND, 32'sh8000_0000, 0, 0, 32'hFFFF_FFFF, 0);
    push_item(OP_SEND, 32'sh7FFF_FFFF, 0, 4096, 0, 0);
    push_item(OP_SEND, 5, 0, 4097, 1, 0);
    push_item(OP_SEND, 5, 0, 16'hFFFF, 1, 1);
    push_item(OP_SEND, 5, 0, 1, 2, 0);
    push_item(OP_RECV, 0, 32'sh7FFF_FFFF, 0, 0, 0);
    push_item(OP_RECV, 0, 32'sh8000_0001, 0, 0, 0);
    push_item(OP_RECV, 0, 32'sh8000_0000, 10, 0, 0);
    push_item(OP_RECV, 0, 0, 10, 0, 0);
    push_item(OP_RECV, 0, 0, 100, 0, 1);
    for (i = 0; i < 17; i++) push_item(OP_SEND, i, 0, 0, i, 0);
    push_item(OP_RECV, 0, 7, 0, 0, 0);
    push_item(OP_RECV, 0, -3, 0, 0, 0);
    drain();
    write_limit(16'd0);
    push_item(OP_SEND, 1, 0, 1, 0, 0);
    push_item(OP_SEND, 1, 0, 1, 0, 1);
    drain();
    write_limit(16'hFFFF);
    push_item(OP_SEND, 1, 0, 16'hFFFF, 9, 0);
    push_item(OP_SEND, 1, 0, 1, 9, 0);
    drain();
    write_limit(16'd1);
    push_item(OP_SEND, 1, 0, 1, 9, 0);
    for (i = 0; i < 20; i++) push_item(OP_RECV, 0, 0, 16'hFFFF, 0, 0);
    drain();
    // random phases over several limits
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: write_limit(16'd4096);
        1: write_limit(16'($urandom_range(1, 300)));
        2: write_limit(16'hFFFF);
        default: write_limit(16'($urandom_range(500, 3000)));
      endcase
      if (ph == 7) quiet_tail = 1;
      for (i = 0; i < 200; i++) random_item((ph % 2) ? 4 : 40);
      drain();
    end
    $display("Run covered %0d transactions, %0d checked, %0d successful receives.",
             sent, mbox.checked, mbox.recv_ok);
    $display("Limits swept from zero to 65535 with sends, receives and stalls.");
    if (mbox.errors == 0 && mbox.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
